@@ rtl/quad_perspective_projection_defines.svh @@
// ---------------------------------------------------------------------------
// Quad perspective projection assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef QUAD_PERSPECTIVE_PROJECTION_DEFINES_SVH
`define QUAD_PERSPECTIVE_PROJECTION_DEFINES_SVH

// same-cycle implication
`define QPP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qpp assertion failed");

// next-cycle implication
`define QPP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qpp assertion failed");

`endif

@@ rtl/qpp_pkg.sv @@
// ---------------------------------------------------------------------------
// qpp_pkg
// Widths, constants and shared types of the quad projection pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package qpp_pkg;

	localparam int LANES    = 4;
	localparam int COORD_W  = 32;
	localparam int TRIG_W   = 16;
	localparam int HALF_W   = 11;
	localparam int SCR_W    = 16;
	localparam int CIDX_W   = 3;
	localparam int FRAC_SH  = 14;

	localparam int X1_W     = 33;
	localparam int MT_W     = 50;
	localparam int T_W      = 36;
	localparam int MY_W     = 54;
	localparam int R_W      = 40;
	localparam int MR_W     = 58;
	localparam int P_W      = 44;
	localparam int D_W      = 41;
	localparam int NUM_W    = 55;
	localparam int MAG_W    = 54;
	localparam int Q_W      = 16;
	localparam int CMP_W    = D_W + Q_W;

	localparam int PRE_LAT  = 9;
	localparam int DIV_LAT  = Q_W + 2;
	localparam int LANE_LAT = PRE_LAT + DIV_LAT;

	localparam logic signed [COORD_W-1:0] EYE_DY     = -32'sd111411;
	localparam logic signed [R_W-1:0]     NEAR_Z     = 40'sd13107;
	localparam logic signed [TRIG_W-1:0]  TILT_COS   = 16'sd15965;
	localparam logic signed [TRIG_W-1:0]  TILT_SIN   = 16'sd3684;
	localparam logic signed [TRIG_W-1:0]  PROJ_SCALE = 16'sd500;
	localparam logic signed [D_W-1:0]     ONE_Q16    = 41'sd65536;
	localparam logic signed [SCR_W-1:0]   SAT_POS    = 16'sh7FFF;
	localparam logic signed [SCR_W-1:0]   SAT_NEG    = 16'sh8000;

	typedef enum logic [CIDX_W-1:0] {
		CFG_VIEWER_X = 3'd0,
		CFG_YAW_COS  = 3'd1,
		CFG_YAW_SIN  = 3'd2,
		CFG_ROLL_COS = 3'd3,
		CFG_ROLL_SIN = 3'd4,
		CFG_HALF_W   = 3'd5,
		CFG_HALF_H   = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] viewer_x;
		logic signed [TRIG_W-1:0]  yaw_cos;
		logic signed [TRIG_W-1:0]  yaw_sin;
		logic signed [TRIG_W-1:0]  roll_cos;
		logic signed [TRIG_W-1:0]  roll_sin;
		logic [HALF_W-1:0]         half_width;
		logic [HALF_W-1:0]         half_height;
	} cfg_t;

	typedef struct packed {
		logic signed [SCR_W-1:0] sx;
		logic signed [SCR_W-1:0] sy;
		logic                    near;
	} lane_res_t;

endpackage
`default_nettype wire

@@ rtl/qpp_div.sv @@
// ---------------------------------------------------------------------------
// qpp_div
// Pipelined restoring divider, one quotient bit per stage, saturating to
// a signed 16-bit result, truncation toward zero.
// ---------------------------------------------------------------------------
`default_nettype none
module qpp_div
	import qpp_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [NUM_W-1:0] num,
	input  wire logic signed [D_W-1:0]   den,
	output logic signed [SCR_W-1:0]      res_q
);

	logic [CMP_W-1:0] rem_s [0:Q_W];
	logic [Q_W-1:0]   quo_s [0:Q_W];
	logic [D_W-1:0]   den_s [0:Q_W];
	logic             neg_s [0:Q_W];
	logic             ovf_s [0:Q_W];

	logic [MAG_W-1:0] mag;
	logic [Q_W-1:0]   qf;
	logic signed [SCR_W-1:0] res_d;

	assign mag = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= num[NUM_W-1];
			rem_s[0] <= CMP_W'(mag);
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= CMP_W'(mag) >= {den, {Q_W{1'b0}}};
		end
	end

	for (genvar i = 0; i < Q_W; i++) begin : g_step
		logic [CMP_W-1:0] sh;
		assign sh = CMP_W'(den_s[i]) << (Q_W - 1 - i);
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[i+1] <= neg_s[i];
				ovf_s[i+1] <= ovf_s[i];
				den_s[i+1] <= den_s[i];
				if (rem_s[i] >= sh) begin
					rem_s[i+1] <= rem_s[i] - sh;
					quo_s[i+1] <= quo_s[i] | (Q_W'(1) << (Q_W - 1 - i));
				end else begin
					rem_s[i+1] <= rem_s[i];
					quo_s[i+1] <= quo_s[i];
				end
			end
		end
	end

	assign qf = quo_s[Q_W];

	always_comb begin
		if (neg_s[Q_W]) begin
			if (ovf_s[Q_W] || (qf[Q_W-1] && (qf[Q_W-2:0] != '0)))
				res_d = SAT_NEG;
			else
				res_d = SCR_W'(-$signed({1'b0, qf}));
		end else begin
			if (ovf_s[Q_W] || qf[Q_W-1])
				res_d = SAT_POS;
			else
				res_d = $signed(qf);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/qpp_lane.sv @@
// ---------------------------------------------------------------------------
// qpp_lane
// One vertex: translate, tilt, yaw, roll, near test and projection with
// two pipelined dividers.
// ---------------------------------------------------------------------------
`default_nettype none
module qpp_lane
	import qpp_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire cfg_t                      cfg,
	input  wire logic signed [COORD_W-1:0] in_x,
	input  wire logic signed [COORD_W-1:0] in_y,
	input  wire logic signed [COORD_W-1:0] in_z,
	output lane_res_t                      res
);

	logic signed [X1_W-1:0]    x_s1, y_s1;
	logic signed [COORD_W-1:0] z_s1;
	logic signed [MT_W-1:0]    ta_s2, tb_s2, tc_s2, td_s2;
	logic signed [X1_W-1:0]    x_s2, x_s3;
	logic signed [T_W-1:0]     y_s3, z_s3, y_s4, y_s5;
	logic signed [MY_W-1:0]    ya_s4, yb_s4, yc_s4, yd_s4;
	logic signed [R_W-1:0]     x_s5, z_s5, z_s6;
	logic signed [MR_W-1:0]    ra_s6, rb_s6, rc_s6, rd_s6;
	logic signed [P_W-1:0]     x_s7, y_s7;
	logic signed [D_W-1:0]     d_s7, d_s8, d_s9;
	logic                      near_s7, near_s8, near_s9;
	logic signed [NUM_W-1:0]   mx_s8, mh_s8, my_s8, mv_s8, nx_s9, ny_s9;
	logic                      near_dq [0:DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= X1_W'(in_x) + X1_W'(cfg.viewer_x);
			y_s1 <= X1_W'(in_y) + X1_W'(EYE_DY);
			z_s1 <= in_z;

			ta_s2 <= MT_W'(y_s1) * MT_W'(TILT_COS);
			tb_s2 <= MT_W'(z_s1) * MT_W'(TILT_SIN);
			tc_s2 <= MT_W'(y_s1) * MT_W'(TILT_SIN);
			td_s2 <= MT_W'(z_s1) * MT_W'(TILT_COS);
			x_s2  <= x_s1;

			y_s3 <= T_W'((ta_s2 - tb_s2) >>> FRAC_SH);
			z_s3 <= T_W'((tc_s2 + td_s2) >>> FRAC_SH);
			x_s3 <= x_s2;

			ya_s4 <= MY_W'(x_s3) * MY_W'(cfg.yaw_cos);
			yb_s4 <= MY_W'(z_s3) * MY_W'(cfg.yaw_sin);
			yc_s4 <= MY_W'(x_s3) * MY_W'(cfg.yaw_sin);
			yd_s4 <= MY_W'(z_s3) * MY_W'(cfg.yaw_cos);
			y_s4  <= y_s3;

			x_s5 <= R_W'((ya_s4 - yb_s4) >>> FRAC_SH);
			z_s5 <= R_W'((yc_s4 + yd_s4) >>> FRAC_SH);
			y_s5 <= y_s4;

			ra_s6 <= MR_W'(x_s5) * MR_W'(cfg.roll_cos);
			rb_s6 <= MR_W'(y_s5) * MR_W'(cfg.roll_sin);
			rc_s6 <= MR_W'(x_s5) * MR_W'(cfg.roll_sin);
			rd_s6 <= MR_W'(y_s5) * MR_W'(cfg.roll_cos);
			z_s6  <= z_s5;

			x_s7    <= P_W'((ra_s6 - rb_s6) >>> FRAC_SH);
			y_s7    <= P_W'((rc_s6 + rd_s6) >>> FRAC_SH);
			d_s7    <= D_W'(z_s6) + ONE_Q16;
			near_s7 <= z_s6 < NEAR_Z;

			mx_s8   <= NUM_W'(x_s7) * NUM_W'(PROJ_SCALE);
			my_s8   <= NUM_W'(y_s7) * NUM_W'(PROJ_SCALE);
			mh_s8   <= NUM_W'(d_s7) * NUM_W'($signed({1'b0, cfg.half_width}));
			mv_s8   <= NUM_W'(d_s7) * NUM_W'($signed({1'b0, cfg.half_height}));
			d_s8    <= d_s7;
			near_s8 <= near_s7;

			nx_s9   <= mx_s8 + mh_s8;
			ny_s9   <= mv_s8 - my_s8;
			d_s9    <= d_s8;
			near_s9 <= near_s8;

			near_dq[0] <= near_s9;
			for (int i = 1; i < DIV_LAT; i++)
				near_dq[i] <= near_dq[i-1];
		end
	end

	qpp_div u_div_x (
		.clk   (clk),
		.en    (en),
		.num   (nx_s9),
		.den   (d_s9),
		.res_q (res.sx)
	);

	qpp_div u_div_y (
		.clk   (clk),
		.en    (en),
		.num   (ny_s9),
		.den   (d_s9),
		.res_q (res.sy)
	);

	assign res.near = near_dq[DIV_LAT-1];

endmodule
`default_nettype wire

@@ rtl/qpp_merge.sv @@
// ---------------------------------------------------------------------------
// qpp_merge
// Combines the four lane results: cull on any near vertex, output register.
// ---------------------------------------------------------------------------
`default_nettype none
module qpp_merge
	import qpp_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     vld,
	input  wire lane_res_t                lane [LANES],
	output logic                          tvalid_q,
	output logic [2*SCR_W*LANES-1:0]      tdata_q,
	output logic                          culled_q
);

	logic                         cull;
	logic [2*SCR_W*LANES-1:0]     data_d;

	always_comb begin
		cull = 1'b0;
		for (int k = 0; k < LANES; k++)
			cull = cull | lane[k].near;
		for (int k = 0; k < LANES; k++) begin
			data_d[2*k*SCR_W +: SCR_W]     = cull ? '0 : lane[k].sx;
			data_d[(2*k+1)*SCR_W +: SCR_W] = cull ? '0 : lane[k].sy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (en) begin
			tvalid_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tdata_q  <= data_d;
			culled_q <= cull;
		end
	end

endmodule
`default_nettype wire

@@ rtl/quad_perspective_projection.sv @@
// ---------------------------------------------------------------------------
// quad_perspective_projection: four-lane rotate and project of one quad
// Takes one quad per cycle while the output is not stalled.
// Depth is set by the 16-stage restoring divider in each lane.
// A stalled output beat freezes the whole pipeline; arst_n restores defaults.
// ---------------------------------------------------------------------------
`default_nettype none
`include "quad_perspective_projection_defines.svh"
module quad_perspective_projection
	import qpp_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// v0_x, v0_y, v0_z, v1_x, ... v3_z, 32 bits each
	input  wire logic [3*COORD_W*LANES-1:0]    s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// p0_sx, p0_sy, p1_sx, ... p3_sy, 16 bits each
	output logic [2*SCR_W*LANES-1:0]           m_axis_tdata,
	// culled
	output logic [0:0]                         m_axis_tuser,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [CIDX_W-1:0]             cfg_index,
	input  wire logic [COORD_W-1:0]            cfg_data
);

	cfg_t              cfg_q;
	logic              en;
	logic [LANE_LAT-1:0] vld_q;
	lane_res_t         lane_res [LANES];

	assign cfg_ready     = 1'b1;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.viewer_x    <= '0;
			cfg_q.yaw_cos     <= 16'sd16384;
			cfg_q.yaw_sin     <= '0;
			cfg_q.roll_cos    <= 16'sd16384;
			cfg_q.roll_sin    <= '0;
			cfg_q.half_width  <= 11'd320;
			cfg_q.half_height <= 11'd240;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_VIEWER_X: cfg_q.viewer_x    <= cfg_data;
				CFG_YAW_COS:  cfg_q.yaw_cos     <= cfg_data[TRIG_W-1:0];
				CFG_YAW_SIN:  cfg_q.yaw_sin     <= cfg_data[TRIG_W-1:0];
				CFG_ROLL_COS: cfg_q.roll_cos    <= cfg_data[TRIG_W-1:0];
				CFG_ROLL_SIN: cfg_q.roll_sin    <= cfg_data[TRIG_W-1:0];
				CFG_HALF_W:   cfg_q.half_width  <= cfg_data[HALF_W-1:0];
				CFG_HALF_H:   cfg_q.half_height <= cfg_data[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LANE_LAT-2:0], s_axis_tvalid};
		end
	end

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		qpp_lane u_lane (
			.clk  (clk),
			.en   (en),
			.cfg  (cfg_q),
			.in_x (s_axis_tdata[(3*k)*COORD_W +: COORD_W]),
			.in_y (s_axis_tdata[(3*k+1)*COORD_W +: COORD_W]),
			.in_z (s_axis_tdata[(3*k+2)*COORD_W +: COORD_W]),
			.res  (lane_res[k])
		);
	end

	qpp_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld      (vld_q[LANE_LAT-1]),
		.lane     (lane_res),
		.tvalid_q (m_axis_tvalid),
		.tdata_q  (m_axis_tdata),
		.culled_q (m_axis_tuser[0])
	);

	`QPP_ASSERT_IMP(a_cull_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)
	`QPP_ASSERT_NXT(a_stall_hold, !s_axis_tready, $stable(vld_q))
	`QPP_ASSERT_IMP(a_stall_ready, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule
`default_nettype wire
